[rtl/ppq_pkg.sv]
// ---------------------------------------------------------------------------
// ppq_pkg: shared types and constants for the priority process queue
// Mode codes, fixed field widths and the result beat layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppq_pkg;

  // Fixed field widths of the ports
  localparam int unsigned ID_BITS    = 4;
  localparam int unsigned MODE_BITS  = 3;
  localparam int unsigned REQ_BITS   = 8;
  localparam int unsigned COUNT_BITS = 5;

  // Distinct ids, hence the most entries the queue can ever hold
  localparam int unsigned ID_COUNT = 2 ** ID_BITS;

  // Operation codes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT      = 3'd0,
    MODE_REMOVE_HEAD = 3'd1,
    MODE_REMOVE_ID   = 3'd2,
    MODE_READ_HEAD   = 3'd3,
    MODE_WALK        = 3'd4
  } mode_t;

  // One result beat
  typedef struct packed {
    logic [ID_BITS-1:0]    entry_id;
    logic                  found;
    logic                  last;
    logic [COUNT_BITS-1:0] queue_count;
    logic                  error;
  } res_t;

endpackage

`default_nettype wire

[rtl/ppq_mem.sv]
// ---------------------------------------------------------------------------
// ppq_mem: entry store of the queue
// Simple dual-port memory, one write and one read port, read data
// registered and held while no read is issued.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/ppq_seq.sv]
// ---------------------------------------------------------------------------
// ppq_seq: operation sequencer of the priority process queue
// Scans the entry memory one entry per cycle, shifts entries to open or
// close a gap, and hands result beats to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppq_seq #(
  parameter int unsigned QUEUE_SLOTS   = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  localparam int unsigned AW = $clog2(QUEUE_SLOTS),
  localparam int unsigned CW = $clog2(QUEUE_SLOTS + 1),
  localparam int unsigned EW = ppq_pkg::ID_BITS + PRIORITY_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input beat
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ppq_pkg::MODE_BITS-1:0] mode,
  input  wire logic [ppq_pkg::ID_BITS-1:0]   slot_id,
  input  wire logic [ppq_pkg::REQ_BITS-1:0]  priority_req,
  // entry memory
  output logic                               rd_en,
  output logic      [AW-1:0]                 rd_addr,
  input  wire logic [EW-1:0]                 rd_data,
  output logic                               wr_en,
  output logic      [AW-1:0]                 wr_addr,
  output logic      [EW-1:0]                 wr_data,
  // result beats
  input  wire logic                          res_room,
  output logic                               res_push,
  output ppq_pkg::res_t                      res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP_SCAN,
    S_INS_SHIFT,
    S_INS_FRONT,
    S_DEL_SCAN,
    S_HEAD_RD,
    S_WALK,
    S_REPLY
  } state_t;

  localparam logic [CW-1:0] FULL = CW'(QUEUE_SLOTS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  state_t                       state, state_next;
  ppq_pkg::mode_t               op;
  logic [ppq_pkg::ID_BITS-1:0]  key_id;
  logic [PRIORITY_BITS-1:0]     key_prio;
  logic [CW-1:0]                occ, occ_next;
  logic [CW-1:0]                sidx, sidx_next;
  logic [CW-1:0]                rptr, rptr_next;
  logic                         pend, pend_next;
  logic                         hit, hit_next;
  logic [ppq_pkg::ID_BITS-1:0]  hit_id, hit_id_next;
  logic [ppq_pkg::ID_BITS-1:0]  r_id, r_id_next;
  logic                         r_found, r_found_next;
  logic                         r_err, r_err_next;

  logic [CW-1:0]                rd_sel, wr_sel;
  logic [PRIORITY_BITS+ppq_pkg::REQ_BITS-1:0] prio_ext;
  logic [PRIORITY_BITS-1:0]     prio_in;
  logic [CW+ppq_pkg::COUNT_BITS-1:0] occ_ext;
  logic [ppq_pkg::COUNT_BITS-1:0]    count;
  logic [ppq_pkg::ID_BITS-1:0]  data_id;
  logic [PRIORITY_BITS-1:0]     data_prio;
  logic                         last_idx;
  logic                         match;
  logic                         consume;
  logic                         issue;

  // Low PRIORITY_BITS of the request, zero above its eight bits
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, priority_req};
  assign prio_in  = prio_ext[PRIORITY_BITS-1:0];

  // Occupancy as reported on the result port
  assign occ_ext = {{ppq_pkg::COUNT_BITS{1'b0}}, occ};
  assign count   = occ_ext[ppq_pkg::COUNT_BITS-1:0];

  // Fields of the entry on the read port
  assign data_id   = rd_data[PRIORITY_BITS +: ppq_pkg::ID_BITS];
  assign data_prio = rd_data[PRIORITY_BITS-1:0];
  assign last_idx  = (sidx == occ - ONE);
  assign match     = (op == ppq_pkg::MODE_REMOVE_HEAD) ? (sidx == '0)
                                                        : (data_id == key_id);

  // Walk: hand the held entry on and fetch the next one in the same cycle
  assign consume = pend && res_room;
  assign issue   = (!pend || consume) && (rptr < occ);

  assign in_ready = (state == S_IDLE);
  assign rd_addr  = rd_sel[AW-1:0];
  assign wr_addr  = wr_sel[AW-1:0];

  // Next state, memory accesses and result beats.
  // Reads always run ahead of or behind the write address of a shift,
  // so a read never meets an entry written by the same operation.
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    sidx_next    = sidx;
    rptr_next    = rptr;
    pend_next    = pend;
    hit_next     = hit;
    hit_id_next  = hit_id;
    r_id_next    = r_id;
    r_found_next = r_found;
    r_err_next   = r_err;
    rd_en        = 1'b0;
    rd_sel       = sidx;
    wr_en        = 1'b0;
    wr_sel       = sidx;
    wr_data      = {key_id, key_prio};
    res_push     = 1'b0;
    res          = '{entry_id: r_id, found: r_found, last: 1'b1,
                     queue_count: count, error: r_err};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          r_id_next    = '0;
          r_found_next = 1'b0;
          r_err_next   = 1'b0;
          hit_next     = 1'b0;
          sidx_next    = '0;
          rptr_next    = '0;
          pend_next    = 1'b0;
          state_next   = S_REPLY;
          case (ppq_pkg::mode_t'(mode))
            ppq_pkg::MODE_INSERT: begin
              if (occ == FULL) begin
                r_err_next = 1'b1;
              end else if (occ == '0) begin
                wr_en    = 1'b1;
                wr_sel   = '0;
                wr_data  = {slot_id, prio_in};
                occ_next = ONE;
              end else begin
                rd_en      = 1'b1;
                rd_sel     = '0;
                state_next = S_DUP_SCAN;
              end
            end
            ppq_pkg::MODE_REMOVE_HEAD, ppq_pkg::MODE_REMOVE_ID: begin
              if (occ != '0) begin
                rd_en      = 1'b1;
                rd_sel     = '0;
                state_next = S_DEL_SCAN;
              end
            end
            ppq_pkg::MODE_READ_HEAD: begin
              if (occ != '0) begin
                rd_en      = 1'b1;
                rd_sel     = '0;
                state_next = S_HEAD_RD;
              end
            end
            ppq_pkg::MODE_WALK: begin
              if (occ != '0) begin
                state_next = S_WALK;
              end
            end
            default: begin
              state_next = S_REPLY;
            end
          endcase
        end
      end

      // Look for the id before the queue is touched
      S_DUP_SCAN: begin
        if (data_id == key_id) begin
          r_err_next = 1'b1;
          state_next = S_REPLY;
        end else if (last_idx) begin
          state_next = S_INS_SHIFT;
        end else begin
          rd_en     = 1'b1;
          rd_sel    = sidx + ONE;
          sidx_next = sidx + ONE;
        end
      end

      // Walk back from the tail, moving lower priorities down one place
      S_INS_SHIFT: begin
        wr_en  = 1'b1;
        wr_sel = sidx + ONE;
        if (data_prio >= key_prio) begin
          occ_next   = occ + ONE;
          state_next = S_REPLY;
        end else begin
          wr_data = rd_data;
          if (sidx == '0) begin
            state_next = S_INS_FRONT;
          end else begin
            rd_en     = 1'b1;
            rd_sel    = sidx - ONE;
            sidx_next = sidx - ONE;
          end
        end
      end

      // New entry goes to the head
      S_INS_FRONT: begin
        wr_en      = 1'b1;
        wr_sel     = '0;
        occ_next   = occ + ONE;
        state_next = S_REPLY;
      end

      // Find the entry, then move every later entry up one place
      S_DEL_SCAN: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_sel  = sidx - ONE;
          wr_data = rd_data;
        end else if (match) begin
          hit_next    = 1'b1;
          hit_id_next = data_id;
        end
        if (last_idx) begin
          if (hit || match) begin
            occ_next     = occ - ONE;
            r_id_next    = hit ? hit_id : data_id;
            r_found_next = 1'b1;
          end
          state_next = S_REPLY;
        end else begin
          rd_en     = 1'b1;
          rd_sel    = sidx + ONE;
          sidx_next = sidx + ONE;
        end
      end

      S_HEAD_RD: begin
        r_id_next    = data_id;
        r_found_next = 1'b1;
        state_next   = S_REPLY;
      end

      // Stream every entry, head first
      S_WALK: begin
        if (consume) begin
          res_push = 1'b1;
          res      = '{entry_id: data_id, found: 1'b1, last: last_idx,
                       queue_count: count, error: 1'b0};
          if (last_idx) begin
            state_next = S_IDLE;
          end
        end
        if (issue) begin
          rd_en     = 1'b1;
          rd_sel    = rptr;
          rptr_next = rptr + ONE;
          sidx_next = rptr;
          pend_next = 1'b1;
        end else if (consume) begin
          pend_next = 1'b0;
        end
      end

      S_REPLY: begin
        if (res_room) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      pend  <= pend_next;
      hit   <= hit_next;
    end
    sidx    <= sidx_next;
    rptr    <= rptr_next;
    hit_id  <= hit_id_next;
    r_id    <= r_id_next;
    r_found <= r_found_next;
    r_err   <= r_err_next;
    if (in_valid && in_ready) begin
      op       <= ppq_pkg::mode_t'(mode);
      key_id   <= slot_id;
      key_prio <= prio_in;
    end
  end

endmodule

`default_nettype wire

[rtl/priority_process_queue.sv]
// ---------------------------------------------------------------------------
// priority_process_queue: process ids ordered by descending priority
// Insert runs a duplicate scan, then a tail-to-gap shift; a walk sends
// one beat per cycle while the sink is ready.
// One item is worked at a time; the next is taken as the final beat leaves.
// Reset empties the queue; the entry memory itself is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_process_queue #(
  parameter int unsigned QUEUE_SLOTS   = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ppq_pkg::MODE_BITS-1:0]   mode,
  input  wire logic [ppq_pkg::ID_BITS-1:0]     slot_id,
  input  wire logic [ppq_pkg::REQ_BITS-1:0]    priority_req,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [ppq_pkg::ID_BITS-1:0]     entry_id,
  output logic                                 found,
  output logic                                 last,
  output logic      [ppq_pkg::COUNT_BITS-1:0]  queue_count,
  output logic                                 error
);

  localparam int unsigned AW = $clog2(QUEUE_SLOTS);
  localparam int unsigned EW = ppq_pkg::ID_BITS + PRIORITY_BITS;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;
  logic          res_room, res_push;
  ppq_pkg::res_t res, out_q;

  ppq_mem #(
    .DEPTH (QUEUE_SLOTS),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppq_seq #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_id      (slot_id),
    .priority_req (priority_req),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res_room     (res_room),
    .res_push     (res_push),
    .res          (res)
  );

  // Output register: takes a new beat whenever it is empty or draining
  assign res_room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_push) begin
      out_q <= res;
    end
  end

  assign entry_id    = out_q.entry_id;
  assign found       = out_q.found;
  assign last        = out_q.last;
  assign queue_count = out_q.queue_count;
  assign error       = out_q.error;

  // One item at a time: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // A refused insert carries no entry and ends its item
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !found && last && entry_id == '0)
    else $error("error beat with entry or without last");

  // Only walk beats can be non-final, and they always carry an entry
  a_walk_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> found && !error)
    else $error("non-final beat without entry");

  // Distinct ids bound the occupancy
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> queue_count <= ppq_pkg::COUNT_BITS'(ppq_pkg::ID_COUNT))
    else $error("queue count beyond id range");

endmodule

`default_nettype wire

[test/tb_priority_process_queue.sv]
// ---------------------------------------------------------------------------
// tb_priority_process_queue: self-checking bench for the priority queue
// Drives insert, remove, read and walk requests over valid/ready with
// random gaps and stalls. A directed table comes first; then random
// fill, drain and mixed segments. Every result beat is checked against the
// table's expected beat or an in-bench model of the ordered queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_priority_process_queue;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned PRIO_BITS = 8;

  // Port field widths
  localparam int unsigned ID_W   = ppq_pkg::ID_BITS;
  localparam int unsigned MODE_W = ppq_pkg::MODE_BITS;
  localparam int unsigned REQ_W  = ppq_pkg::REQ_BITS;
  localparam int unsigned CNT_W  = ppq_pkg::COUNT_BITS;

  localparam logic [REQ_W-1:0] PRIO_MASK = REQ_W'((64'd1 << PRIO_BITS) - 1);

  // Mode codes the block treats as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS   = 75;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_MSG_LINES  = 50;

  localparam ppq_pkg::res_t NO_BEAT = '0;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [ID_W-1:0]   id;
    logic [REQ_W-1:0]  req;
    bit                typed;
    ppq_pkg::res_t     want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [ID_W-1:0]   slot_id = '0;
  logic [REQ_W-1:0]  priority_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   entry_id;
  logic              found;
  logic              last;
  logic [CNT_W-1:0]  queue_count;
  logic              error;

  // Model of the ordered queue, head at index 0
  logic [ID_W-1:0]  queue_ids   [SLOTS];
  logic [REQ_W-1:0] queue_prios [SLOTS];
  int               queue_len = 0;

  ppq_pkg::res_t expected_beats[$];

  int  mismatches     = 0;
  int  items_sent     = 0;
  int  beats_checked  = 0;
  int  refused_count  = 0;
  int  walk_count     = 0;
  int  peak_len       = 0;
  int  idle_cycles    = 0;
  bit  steady_in      = 1'b0;
  bit  steady_out     = 1'b0;

  priority_process_queue #(
    .QUEUE_SLOTS   (SLOTS),
    .PRIORITY_BITS (PRIO_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_id      (slot_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .entry_id     (entry_id),
    .found        (found),
    .last         (last),
    .queue_count  (queue_count),
    .error        (error)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ppq_pkg::res_t make_beat(input logic [ID_W-1:0] id, input logic fnd,
                                              input logic lst, input int cnt,
                                              input logic err);
    ppq_pkg::res_t b;
    b.entry_id    = id;
    b.found       = fnd;
    b.last        = lst;
    b.queue_count = CNT_W'(cnt);
    b.error       = err;
    return b;
  endfunction

  // Single beat with no entry, as for inserts and empty or absent cases
  function automatic ppq_pkg::res_t idle_beat(input int cnt, input logic err);
    return make_beat('0, 1'b0, 1'b1, cnt, err);
  endfunction

  function automatic stim_row_t stim(input logic [MODE_W-1:0] op,
                                     input logic [ID_W-1:0] id,
                                     input logic [REQ_W-1:0] req,
                                     input bit typed, input ppq_pkg::res_t want);
    stim_row_t r;
    r.op    = op;
    r.id    = id;
    r.req   = req;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Position of an id in the queue, -1 when absent
  function automatic int locate(input logic [ID_W-1:0] id);
    for (int i = 0; i < queue_len; i++)
      if (queue_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [ID_W-1:0] pick_absent_id();
    logic [ID_W-1:0] id;
    id = ID_W'($urandom_range(0, SLOTS - 1));
    while (locate(id) >= 0) id = id + 1'b1;
    return id;
  endfunction

  function automatic logic [ID_W-1:0] pick_present_id();
    return queue_ids[$urandom_range(0, queue_len - 1)];
  endfunction

  task automatic drop_at(input int pos);
    for (int i = pos; i + 1 < queue_len; i++) begin
      queue_ids[i]   = queue_ids[i + 1];
      queue_prios[i] = queue_prios[i + 1];
    end
    queue_len--;
  endtask

  // Apply one request to the queue model and produce its result beats
  task automatic apply_queue_op(input logic [MODE_W-1:0] op,
                                input logic [ID_W-1:0] id,
                                input logic [REQ_W-1:0] req,
                                output ppq_pkg::res_t beats[SLOTS], output int n);
    int               pos;
    int               where;
    logic [REQ_W-1:0] p;
    logic [ID_W-1:0]  h;
    p = req & PRIO_MASK;
    n = 1;
    case (op)
      ppq_pkg::MODE_INSERT: begin
        if (queue_len >= SLOTS || locate(id) >= 0) begin
          beats[0] = make_beat('0, 1'b0, 1'b1, queue_len, 1'b1);
          refused_count++;
        end else begin
          // new entry goes behind every entry of greater or equal priority
          pos = 0;
          while (pos < queue_len && queue_prios[pos] >= p) pos++;
          for (int i = queue_len; i > pos; i--) begin
            queue_ids[i]   = queue_ids[i - 1];
            queue_prios[i] = queue_prios[i - 1];
          end
          queue_ids[pos]   = id;
          queue_prios[pos] = p;
          queue_len++;
          if (queue_len > peak_len) peak_len = queue_len;
          beats[0] = make_beat('0, 1'b0, 1'b1, queue_len, 1'b0);
        end
      end
      ppq_pkg::MODE_REMOVE_HEAD: begin
        if (queue_len == 0) begin
          beats[0] = make_beat('0, 1'b0, 1'b1, 0, 1'b0);
        end else begin
          h = queue_ids[0];
          drop_at(0);
          beats[0] = make_beat(h, 1'b1, 1'b1, queue_len, 1'b0);
        end
      end
      ppq_pkg::MODE_REMOVE_ID: begin
        where = locate(id);
        if (where < 0) begin
          beats[0] = make_beat('0, 1'b0, 1'b1, queue_len, 1'b0);
        end else begin
          drop_at(where);
          beats[0] = make_beat(id, 1'b1, 1'b1, queue_len, 1'b0);
        end
      end
      ppq_pkg::MODE_READ_HEAD: begin
        if (queue_len == 0) beats[0] = make_beat('0, 1'b0, 1'b1, 0, 1'b0);
        else beats[0] = make_beat(queue_ids[0], 1'b1, 1'b1, queue_len, 1'b0);
      end
      ppq_pkg::MODE_WALK: begin
        walk_count++;
        if (queue_len == 0) begin
          beats[0] = make_beat('0, 1'b0, 1'b1, 0, 1'b0);
        end else begin
          for (int i = 0; i < queue_len; i++)
            beats[i] = make_beat(queue_ids[i], 1'b1, (i + 1 == queue_len),
                                 queue_len, 1'b0);
          n = queue_len;
        end
      end
      default: beats[0] = make_beat('0, 1'b0, 1'b1, queue_len, 1'b0);
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_MSG_LINES) $display("tb: mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Send one request beat; on acceptance, queue up what it should produce
  task automatic drive_request(input logic [MODE_W-1:0] op,
                               input logic [ID_W-1:0] id,
                               input logic [REQ_W-1:0] req,
                               input bit typed, input ppq_pkg::res_t want);
    int            gap;
    int            n;
    ppq_pkg::res_t beats[SLOTS];
    gap = steady_in ? 0 : int'($urandom_range(0, 9));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= op;
    slot_id      <= id;
    priority_req <= req;
    do @(posedge clk); while (!in_ready);
    apply_queue_op(op, id, req, beats, n);
    if (typed) expected_beats.push_back(want);
    else for (int i = 0; i < n; i++) expected_beats.push_back(beats[i]);
    items_sent++;
  endtask

  task automatic random_insert(input bit tie_heavy, input bit allow_dup);
    logic [ID_W-1:0]  id;
    logic [REQ_W-1:0] req;
    if (allow_dup || queue_len >= SLOTS) id = ID_W'($urandom_range(0, SLOTS - 1));
    else id = pick_absent_id();
    req = tie_heavy ? REQ_W'($urandom_range(0, 3)) : REQ_W'($urandom_range(0, 255));
    drive_request(ppq_pkg::MODE_INSERT, id, req, 1'b0, NO_BEAT);
  endtask

  // Result side: random stall per beat, then check against the oldest expectation
  initial begin : result_sink
    int            stall;
    ppq_pkg::res_t got;
    ppq_pkg::res_t want;
    wait (!rst);
    forever begin
      stall = steady_out ? 0 : int'($urandom_range(0, 9));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = make_beat(entry_id, found, last, int'(queue_count), error);
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", got));
      end else begin
        want = expected_beats.pop_front();
        if (got.entry_id !== want.entry_id)
          report_mismatch($sformatf("entry_id %0d, want %0d", got.entry_id, want.entry_id));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (got.queue_count !== want.queue_count)
          report_mismatch($sformatf("queue_count %0d, want %0d",
                                    got.queue_count, want.queue_count));
        if (got.error !== want.error)
          report_mismatch($sformatf("error %0b, want %0b", got.error, want.error));
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: watchdog expired, %0d beats still expected", expected_beats.size());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t       directed[$];
    int              directed_items;
    int              seg;
    int              kind;
    int              r;
    bit              tie_heavy;
    logic [ID_W-1:0] id;

    // Directed table: empty-queue cases, extremes, ties, duplicates
    directed.push_back(stim(ppq_pkg::MODE_READ_HEAD, 4'd0, 8'd0, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_HEAD, 4'd0, 8'd0, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_ID, 4'd15, 8'd255, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_WALK, 4'd0, 8'd0, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(MODE_SPARE_FIRST, 4'd3, 8'd9, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(MODE_SPARE_LAST, 4'd15, 8'd255, 1'b1, idle_beat(0, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd0, 8'd0, 1'b1, idle_beat(1, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd15, 8'd255, 1'b1, idle_beat(2, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd15, 8'd7, 1'b1, idle_beat(2, 1'b1)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd5, 8'd255, 1'b1, idle_beat(3, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd6, 8'd0, 1'b1, idle_beat(4, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd9, 8'd128, 1'b1, idle_beat(5, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd0, 8'd200, 1'b1, idle_beat(5, 1'b1)));
    directed.push_back(stim(ppq_pkg::MODE_WALK, 4'd0, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_READ_HEAD, 4'd0, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_ID, 4'd9, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_ID, 4'd9, 8'd0, 1'b1, idle_beat(4, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_HEAD, 4'd0, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(MODE_SPARE_MID, 4'd10, 8'd170, 1'b1, idle_beat(3, 1'b0)));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd10, 8'h55, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_INSERT, 4'd3, 8'hAA, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_WALK, 4'd0, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_ID, 4'd6, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_REMOVE_HEAD, 4'd0, 8'd0, 1'b0, NO_BEAT));
    directed.push_back(stim(ppq_pkg::MODE_WALK, 4'd0, 8'd0, 1'b0, NO_BEAT));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      drive_request(directed[i].op, directed[i].id, directed[i].req,
                    directed[i].typed, directed[i].want);
    directed_items = items_sent;

    // Random segments: fill to full, drain to empty, or mixed traffic
    seg = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      kind       = (seg < 3) ? seg : int'($urandom_range(0, 2));
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      tie_heavy  = ($urandom_range(0, 1) == 1);
      case (kind)
        0: begin
          // fill, then inserts against a full queue, then walk it
          while (queue_len < SLOTS) random_insert(tie_heavy, $urandom_range(0, 4) == 0);
          repeat (2) random_insert(tie_heavy, 1'b1);
          drive_request(ppq_pkg::MODE_WALK, '0, '0, 1'b0, NO_BEAT);
        end
        1: begin
          repeat (12) begin
            r = int'($urandom_range(0, 99));
            id = ID_W'($urandom_range(0, SLOTS - 1));
            if (r < 35) random_insert(tie_heavy, 1'b1);
            else if (r < 50) drive_request(ppq_pkg::MODE_REMOVE_HEAD, id, '0, 1'b0, NO_BEAT);
            else if (r < 65) begin
              if (queue_len > 0 && $urandom_range(0, 1) == 1) id = pick_present_id();
              drive_request(ppq_pkg::MODE_REMOVE_ID, id, REQ_W'($urandom_range(0, 255)),
                            1'b0, NO_BEAT);
            end
            else if (r < 75) drive_request(ppq_pkg::MODE_READ_HEAD, id, '0, 1'b0, NO_BEAT);
            else if (r < 88) drive_request(ppq_pkg::MODE_WALK, id, '0, 1'b0, NO_BEAT);
            else drive_request(MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                               id, REQ_W'($urandom_range(0, 255)), 1'b0, NO_BEAT);
          end
        end
        default: begin
          // drain by head and by name, then hit the empty queue
          while (queue_len > 0) begin
            r = int'($urandom_range(0, 99));
            if (r < 45) drive_request(ppq_pkg::MODE_REMOVE_HEAD, '0, '0, 1'b0, NO_BEAT);
            else if (r < 85) drive_request(ppq_pkg::MODE_REMOVE_ID, pick_present_id(), '0,
                                           1'b0, NO_BEAT);
            else drive_request(ppq_pkg::MODE_READ_HEAD, '0, '0, 1'b0, NO_BEAT);
          end
          drive_request(ppq_pkg::MODE_REMOVE_HEAD, '0, '0, 1'b0, NO_BEAT);
          drive_request(ppq_pkg::MODE_READ_HEAD, '0, '0, 1'b0, NO_BEAT);
          drive_request(ppq_pkg::MODE_WALK, '0, '0, 1'b0, NO_BEAT);
        end
      endcase
      seg++;
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d requests (%0d from the table), %0d result beats checked",
             items_sent, directed_items, beats_checked);
    $display("tb: %0d refused inserts, %0d walks, peak occupancy %0d, %0d mismatches",
             refused_count, walk_count, peak_len, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
